// ----- rtl/tilt_angle_kalman_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter assertion macros
// Concurrent assertion wrappers; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, off during reset
`define TAK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tak assertion failed");
// clocked assertion, also checked during reset
`define TAK_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tak assertion failed");
`else
`define TAK_ASSERT(label, clk, rst_n, prop)
`define TAK_ASSERT_NORST(label, clk, prop)
`endif

`endif

// ----- rtl/tak_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter package
// Shared types, command codes, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tak_pkg;

  localparam int CORDIC_ITERS = 40;
  localparam int DIV_STEPS    = 92;
  localparam int MUL_STEPS    = 4;

  localparam logic signed [47:0] PI_Q44         = 48'sh3243F6A8885A;
  localparam logic signed [47:0] HALF_PI_Q44    = 48'sh1921FB54442D;
  localparam logic signed [47:0] QUARTER_PI_Q44 = 48'sh0C90FDAA2217;
  localparam logic signed [47:0] Q_ONE          = 48'sh100000000000;

  // datapath commands
  localparam logic [3:0] CMD_NOP       = 4'd0;
  localparam logic [3:0] CMD_ACCEPT    = 4'd1;
  localparam logic [3:0] CMD_CORD_INIT = 4'd2;
  localparam logic [3:0] CMD_CORD_ITER = 4'd3;
  localparam logic [3:0] CMD_MUL_START = 4'd4;
  localparam logic [3:0] CMD_MUL_STEP  = 4'd5;
  localparam logic [3:0] CMD_MUL_RND   = 4'd6;
  localparam logic [3:0] CMD_MUL_FIN   = 4'd7;
  localparam logic [3:0] CMD_MUL_WB    = 4'd8;
  localparam logic [3:0] CMD_DIV_INIT  = 4'd9;
  localparam logic [3:0] CMD_DIV_ITER  = 4'd10;
  localparam logic [3:0] CMD_DIV_FIN   = 4'd11;
  localparam logic [3:0] CMD_PREP      = 4'd12;
  localparam logic [3:0] CMD_STORE     = 4'd13;

  // product sequence
  localparam logic [3:0] MUL_TS_X1   = 4'd0;
  localparam logic [3:0] MUL_TS_GYRO = 4'd1;
  localparam logic [3:0] MUL_TS_P10  = 4'd2;
  localparam logic [3:0] MUL_TS_P11  = 4'd3;
  localparam logic [3:0] MUL_TS_T01  = 4'd4;
  localparam logic [3:0] MUL_K0_E    = 4'd5;
  localparam logic [3:0] MUL_K1_E    = 4'd6;
  localparam logic [3:0] MUL_G_M00   = 4'd7;
  localparam logic [3:0] MUL_G_M01   = 4'd8;
  localparam logic [3:0] MUL_K1_M00  = 4'd9;
  localparam logic [3:0] MUL_K1_M01  = 4'd10;

  // config register indexes
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_NOISE_ANGLE   = 2'd1;
  localparam logic [1:0] REG_NOISE_BIAS    = 2'd2;
  localparam logic [1:0] REG_MEAS_NOISE    = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] mul_id;
    logic [5:0] idx;
  } tak_cmd_t;

  typedef struct packed {
    logic out_full;
  } tak_status_t;

  typedef logic [CORDIC_ITERS-1:0][47:0] tak_atan_tab_t;

  // atan(2^-i) in Q4.44, series evaluated in 64-bit integer arithmetic
  function automatic tak_atan_tab_t build_atan_tab();
    tak_atan_tab_t t;
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    t = '0;
    t[0] = QUARTER_PI_Q44;
    for (int i = 1; i < CORDIC_ITERS; i++) begin
      p   = 64'd1 << (62 - i);
      sum = '0;
      for (int k = 0; k < 32; k++) begin
        if (p != 64'd0) begin
          term = p / 64'(2 * k + 1);
          if ((k % 2) == 1) sum = sum - term;
          else sum = sum + term;
          if (2 * i < 63) p = p >> (2 * i);
          else p = '0;
        end
      end
      rnd  = (sum + (64'd1 << 17)) >> 18;
      t[i] = rnd[47:0];
    end
    return t;
  endfunction

  localparam tak_atan_tab_t ATAN_TAB = build_atan_tab();

  // saturate a widened sum to Q4.44
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    if (v[51:47] == 5'b00000 || v[51:47] == 5'b11111) return v[47:0];
    else if (v[51]) return 48'sh800000000000;
    else return 48'sh7FFFFFFFFFFF;
  endfunction

  function automatic logic signed [51:0] sx52(input logic signed [47:0] v);
    return {{4{v[47]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tak_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter controller
// Sequences CORDIC, shared multiplier, divider and state write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tak_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tak_pkg::tak_status_t status_i,
  output tak_pkg::tak_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CINIT  = 4'd1;
  localparam logic [3:0] S_CITER  = 4'd2;
  localparam logic [3:0] S_MSTART = 4'd3;
  localparam logic [3:0] S_MSTEP  = 4'd4;
  localparam logic [3:0] S_MRND   = 4'd5;
  localparam logic [3:0] S_MFIN   = 4'd6;
  localparam logic [3:0] S_MWB    = 4'd7;
  localparam logic [3:0] S_DINIT  = 4'd8;
  localparam logic [3:0] S_DITER  = 4'd9;
  localparam logic [3:0] S_DFIN   = 4'd10;
  localparam logic [3:0] S_PREP   = 4'd11;
  localparam logic [3:0] S_STORE  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [3:0] mid_q, mid_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mid_d        = mid_q;
    cmd_o.op     = tak_pkg::CMD_NOP;
    cmd_o.mul_id = mid_q;
    cmd_o.idx    = cnt_q[5:0];
    in_stall_o   = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tak_pkg::CMD_ACCEPT;
          state_d  = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd_o.op = tak_pkg::CMD_CORD_INIT;
        cnt_d    = '0;
        state_d  = S_CITER;
      end
      S_CITER: begin
        cmd_o.op = tak_pkg::CMD_CORD_ITER;
        if (cnt_q == 7'(tak_pkg::CORDIC_ITERS - 1)) begin
          cnt_d   = '0;
          mid_d   = tak_pkg::MUL_TS_X1;
          state_d = S_MSTART;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_MSTART: begin
        cmd_o.op = tak_pkg::CMD_MUL_START;
        cnt_d    = '0;
        state_d  = S_MSTEP;
      end
      S_MSTEP: begin
        cmd_o.op = tak_pkg::CMD_MUL_STEP;
        if (cnt_q == 7'(tak_pkg::MUL_STEPS - 1)) state_d = S_MRND;
        else cnt_d = cnt_q + 7'd1;
      end
      S_MRND: begin
        cmd_o.op = tak_pkg::CMD_MUL_RND;
        state_d  = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.op = tak_pkg::CMD_MUL_FIN;
        state_d  = S_MWB;
      end
      S_MWB: begin
        cmd_o.op = tak_pkg::CMD_MUL_WB;
        if (mid_q == tak_pkg::MUL_TS_T01) begin
          state_d = S_DINIT;
        end else if (mid_q == tak_pkg::MUL_K1_M01) begin
          state_d = S_STORE;
        end else begin
          mid_d   = mid_q + 4'd1;
          state_d = S_MSTART;
        end
      end
      S_DINIT: begin
        cmd_o.op = tak_pkg::CMD_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DITER;
      end
      S_DITER: begin
        cmd_o.op = tak_pkg::CMD_DIV_ITER;
        if (cnt_q == 7'(tak_pkg::DIV_STEPS - 1)) state_d = S_DFIN;
        else cnt_d = cnt_q + 7'd1;
      end
      S_DFIN: begin
        cmd_o.op = tak_pkg::CMD_DIV_FIN;
        state_d  = S_PREP;
      end
      S_PREP: begin
        cmd_o.op = tak_pkg::CMD_PREP;
        mid_d    = tak_pkg::MUL_K0_E;
        state_d  = S_MSTART;
      end
      S_STORE: begin
        // hold until the output register can take the item
        if (!status_i.out_full) begin
          cmd_o.op = tak_pkg::CMD_STORE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mid_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mid_q   <= mid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tak_datapath.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter datapath
// Filter banks, config registers, CORDIC, shared multiplier, divider, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tak_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [44:0]          cfg_data_i,
  input  wire logic                 axis_i,
  input  wire logic signed [15:0]   accel_lateral_i,
  input  wire logic signed [15:0]   accel_vertical_i,
  input  wire logic signed [31:0]   gyro_rate_i,
  input  wire tak_pkg::tak_cmd_t    cmd_i,
  output tak_pkg::tak_status_t      status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      axis_out_o,
  output logic signed [31:0]        angle_estimate_o
);

  localparam logic [1:0] SH_12 = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_44 = 2'd2;

  // config
  logic [28:0] ts_q;
  logic [31:0] qa_q, qb_q;
  logic [44:0] rn_q;

  // banks
  logic signed [47:0] ang_q [2];
  logic signed [47:0] bias_q [2];
  logic signed [47:0] c00_q [2];
  logic signed [47:0] c01_q [2];
  logic signed [47:0] c10_q [2];
  logic signed [47:0] c11_q [2];

  // item working set
  logic               ax_q;
  logic signed [15:0] lat_q, vert_q;
  logic signed [31:0] gyro_q;
  logic signed [47:0] x0_q, x1_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [47:0] r0_q, xa_q, t00_q, t01_q, m00_q, m10_q, m11_q;
  logic signed [47:0] k0_q, k1_q, e_q, g_q;
  logic signed [47:0] nx0_q, nx1_q, np00_q, np01_q, np10_q, np11_q;

  // CORDIC
  logic signed [47:0] cx_q, cy_q, cz_q;
  logic               cfix_q;

  // multiplier
  logic [47:0]        ma_q, mb_q;
  logic               mneg_q;
  logic [1:0]         msh_q;
  logic [95:0]        acc_q;
  logic [96:0]        rnd_q;
  logic signed [47:0] mres_q;

  // divider
  logic [47:0] dd_q;
  logic [91:0] n0_q, n1_q;
  logic [48:0] rem0_q, rem1_q;
  logic [50:0] q0_q, q1_q;
  logic        big0_q, big1_q, neg0_q, neg1_q;

  // output
  logic               ovld_q;
  logic               oax_q;
  logic signed [31:0] oang_q;

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  typedef struct packed {
    logic [48:0] rem;
    logic [50:0] q;
    logic        big;
  } div_st_t;

  function automatic div_st_t div_step(input logic [48:0] rem, input logic [50:0] q,
                                       input logic big, input logic nbit,
                                       input logic [47:0] d);
    div_st_t    r;
    logic [48:0] rs;
    rs    = {rem[47:0], nbit};
    r.big = big | q[50];
    r.q   = {q[49:0], 1'b0};
    r.rem = rs;
    if (rs >= {1'b0, d}) begin
      r.rem  = rs - {1'b0, d};
      r.q[0] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [47:0] div_fin(input logic [48:0] rem, input logic [50:0] q,
                                                 input logic big, input logic neg,
                                                 input logic [47:0] d);
    logic [51:0] qr;
    logic [51:0] lim;
    qr  = {1'b0, q} + 52'(({rem, 1'b0} >= {2'b00, d}));
    lim = neg ? 52'h0800000000000 : 52'h07FFFFFFFFFFF;
    if (big || qr > lim) qr = lim;
    return neg ? 48'(-qr[47:0]) : qr[47:0];
  endfunction

  // multiplier operand selection
  logic signed [47:0] op_a, op_b;
  logic [1:0]         op_sh;
  logic signed [47:0] ts_s;
  assign ts_s = {19'b0, ts_q};

  always_comb begin
    op_a  = ts_s;
    op_b  = x1_q;
    op_sh = SH_32;
    case (cmd_i.mul_id)
      tak_pkg::MUL_TS_X1:   begin op_a = ts_s; op_b = x1_q; op_sh = SH_32; end
      tak_pkg::MUL_TS_GYRO: begin
        op_a = ts_s; op_b = {{16{gyro_q[31]}}, gyro_q}; op_sh = SH_12;
      end
      tak_pkg::MUL_TS_P10:  begin op_a = ts_s; op_b = p10_q; op_sh = SH_32; end
      tak_pkg::MUL_TS_P11:  begin op_a = ts_s; op_b = p11_q; op_sh = SH_32; end
      tak_pkg::MUL_TS_T01:  begin op_a = ts_s; op_b = t01_q; op_sh = SH_32; end
      tak_pkg::MUL_K0_E:    begin op_a = k0_q; op_b = e_q;   op_sh = SH_44; end
      tak_pkg::MUL_K1_E:    begin op_a = k1_q; op_b = e_q;   op_sh = SH_44; end
      tak_pkg::MUL_G_M00:   begin op_a = g_q;  op_b = m00_q; op_sh = SH_44; end
      tak_pkg::MUL_G_M01:   begin op_a = g_q;  op_b = t01_q; op_sh = SH_44; end
      tak_pkg::MUL_K1_M00:  begin op_a = k1_q; op_b = m00_q; op_sh = SH_44; end
      tak_pkg::MUL_K1_M01:  begin op_a = k1_q; op_b = t01_q; op_sh = SH_44; end
      default: ;
    endcase
  end

  // one 24x24 partial product per step
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  assign pa = cmd_i.idx[1] ? ma_q[47:24] : ma_q[23:0];
  assign pb = cmd_i.idx[0] ? mb_q[47:24] : mb_q[23:0];
  assign pp = pa * pb;

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    pp_sh = {48'b0, pp};
      2'd3:    pp_sh = {pp, 48'b0};
      default: pp_sh = {24'b0, pp, 24'b0};
    endcase
  end

  logic [96:0] half;
  logic [96:0] shifted;
  logic [96:0] mlim;
  logic [96:0] mmag;
  always_comb begin
    case (msh_q)
      SH_12:   half = 97'd1 << 11;
      SH_32:   half = 97'd1 << 31;
      default: half = 97'd1 << 43;
    endcase
    case (msh_q)
      SH_12:   shifted = rnd_q >> 12;
      SH_32:   shifted = rnd_q >> 32;
      default: shifted = rnd_q >> 44;
    endcase
    mlim = mneg_q ? (97'd1 << 47) : ((97'd1 << 47) - 97'd1);
    mmag = (shifted > mlim) ? mlim : shifted;
  end

  // CORDIC
  logic signed [47:0] vx, vy, xs, ys;
  logic               lat_zero;
  assign vx       = {{8{vert_q[15]}}, vert_q, 24'b0};
  assign vy       = 48'(-{{8{lat_q[15]}}, lat_q, 24'b0});
  assign lat_zero = (lat_q == 16'sd0);
  assign xs       = cx_q >>> cmd_i.idx;
  assign ys       = cy_q >>> cmd_i.idx;

  // divider
  logic signed [51:0] s_sum;
  div_st_t            ds0, ds1;
  assign s_sum = tak_pkg::sx52(m00_q) + {7'b0, rn_q};
  assign ds0   = div_step(rem0_q, q0_q, big0_q, n0_q[91], dd_q);
  assign ds1   = div_step(rem1_q, q1_q, big1_q, n1_q[91], dd_q);

  assign status_o.out_full = ovld_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= 29'd21474836;
      qa_q   <= 32'd1759;
      qb_q   <= 32'd1759;
      rn_q   <= 45'd1759218604;
      ovld_q <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        ang_q[a]  <= '0;
        bias_q[a] <= '0;
        c00_q[a]  <= tak_pkg::Q_ONE;
        c01_q[a]  <= '0;
        c10_q[a]  <= '0;
        c11_q[a]  <= tak_pkg::Q_ONE;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tak_pkg::REG_SAMPLE_PERIOD: ts_q <= cfg_data_i[28:0];
          tak_pkg::REG_NOISE_ANGLE:   qa_q <= cfg_data_i[31:0];
          tak_pkg::REG_NOISE_BIAS:    qb_q <= cfg_data_i[31:0];
          tak_pkg::REG_MEAS_NOISE:    rn_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == tak_pkg::CMD_STORE) begin
        ovld_q        <= 1'b1;
        ang_q[ax_q]  <= nx0_q;
        bias_q[ax_q] <= nx1_q;
        c00_q[ax_q]  <= np00_q;
        c01_q[ax_q]  <= np01_q;
        c10_q[ax_q]  <= np10_q;
        c11_q[ax_q]  <= np11_q;
      end else if (ovld_q && !out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tak_pkg::CMD_ACCEPT: begin
        ax_q   <= axis_i;
        lat_q  <= accel_lateral_i;
        vert_q <= accel_vertical_i;
        gyro_q <= gyro_rate_i;
        x0_q   <= ang_q[axis_i];
        x1_q   <= bias_q[axis_i];
        p00_q  <= c00_q[axis_i];
        p01_q  <= c01_q[axis_i];
        p10_q  <= c10_q[axis_i];
        p11_q  <= c11_q[axis_i];
      end
      tak_pkg::CMD_CORD_INIT: begin
        cfix_q <= 1'b0;
        cx_q   <= vx;
        cy_q   <= vy;
        cz_q   <= '0;
        if (lat_zero && vert_q == 16'sd0) begin
          cfix_q <= 1'b1;
        end else if (lat_zero && vert_q[15]) begin
          // negated zero lateral counts as negative: angle is -pi
          cfix_q <= 1'b1;
          cz_q   <= -tak_pkg::PI_Q44;
        end else if (vx[47]) begin
          if (!vy[47] && vy != 48'sd0) begin
            cx_q <= vy;
            cy_q <= -vx;
            cz_q <= tak_pkg::HALF_PI_Q44;
          end else begin
            cx_q <= -vy;
            cy_q <= vx;
            cz_q <= -tak_pkg::HALF_PI_Q44;
          end
        end
      end
      tak_pkg::CMD_CORD_ITER: begin
        if (!cfix_q) begin
          if (!cy_q[47]) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + tak_pkg::ATAN_TAB[cmd_i.idx];
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - tak_pkg::ATAN_TAB[cmd_i.idx];
          end
        end
      end
      tak_pkg::CMD_MUL_START: begin
        ma_q   <= mag48(op_a);
        mb_q   <= mag48(op_b);
        mneg_q <= op_a[47] ^ op_b[47];
        msh_q  <= op_sh;
        acc_q  <= '0;
      end
      tak_pkg::CMD_MUL_STEP: acc_q <= acc_q + pp_sh;
      tak_pkg::CMD_MUL_RND:  rnd_q <= {1'b0, acc_q} + half;
      tak_pkg::CMD_MUL_FIN:  mres_q <= mneg_q ? 48'(-mmag[47:0]) : mmag[47:0];
      tak_pkg::CMD_MUL_WB: begin
        case (cmd_i.mul_id)
          tak_pkg::MUL_TS_X1:   r0_q <= mres_q;
          tak_pkg::MUL_TS_GYRO: xa_q <= tak_pkg::sat48(tak_pkg::sx52(x0_q)
                                  - tak_pkg::sx52(r0_q) + tak_pkg::sx52(mres_q));
          tak_pkg::MUL_TS_P10:  t00_q <= tak_pkg::sat48(tak_pkg::sx52(p00_q)
                                  - tak_pkg::sx52(mres_q));
          tak_pkg::MUL_TS_P11: begin
            t01_q <= tak_pkg::sat48(tak_pkg::sx52(p01_q) - tak_pkg::sx52(mres_q));
            m10_q <= tak_pkg::sat48(tak_pkg::sx52(p10_q) - tak_pkg::sx52(mres_q));
          end
          tak_pkg::MUL_TS_T01: begin
            m00_q <= tak_pkg::sat48(tak_pkg::sx52(t00_q) - tak_pkg::sx52(mres_q)
                     + {20'b0, qa_q});
            m11_q <= tak_pkg::sat48(tak_pkg::sx52(p11_q) + {20'b0, qb_q});
          end
          tak_pkg::MUL_K0_E:  nx0_q <= tak_pkg::sat48(tak_pkg::sx52(xa_q)
                                + tak_pkg::sx52(mres_q));
          tak_pkg::MUL_K1_E:  nx1_q <= tak_pkg::sat48(tak_pkg::sx52(x1_q)
                                + tak_pkg::sx52(mres_q));
          tak_pkg::MUL_G_M00: np00_q <= mres_q;
          tak_pkg::MUL_G_M01: np01_q <= mres_q;
          tak_pkg::MUL_K1_M00: np10_q <= tak_pkg::sat48(tak_pkg::sx52(m10_q)
                                 - tak_pkg::sx52(mres_q));
          tak_pkg::MUL_K1_M01: np11_q <= tak_pkg::sat48(tak_pkg::sx52(m11_q)
                                 - tak_pkg::sx52(mres_q));
          default: ;
        endcase
      end
      tak_pkg::CMD_DIV_INIT: begin
        // nonpositive innovation variance is taken as one lsb
        dd_q   <= (s_sum[51] || s_sum == 52'sd0) ? 48'd1 : s_sum[47:0];
        n0_q   <= {mag48(m00_q), 44'b0};
        n1_q   <= {mag48(m10_q), 44'b0};
        rem0_q <= '0;
        rem1_q <= '0;
        q0_q   <= '0;
        q1_q   <= '0;
        big0_q <= 1'b0;
        big1_q <= 1'b0;
        neg0_q <= m00_q[47];
        neg1_q <= m10_q[47];
      end
      tak_pkg::CMD_DIV_ITER: begin
        rem0_q <= ds0.rem;
        q0_q   <= ds0.q;
        big0_q <= ds0.big;
        rem1_q <= ds1.rem;
        q1_q   <= ds1.q;
        big1_q <= ds1.big;
        n0_q   <= {n0_q[90:0], 1'b0};
        n1_q   <= {n1_q[90:0], 1'b0};
      end
      tak_pkg::CMD_DIV_FIN: begin
        k0_q <= div_fin(rem0_q, q0_q, big0_q, neg0_q, dd_q);
        k1_q <= div_fin(rem1_q, q1_q, big1_q, neg1_q, dd_q);
      end
      tak_pkg::CMD_PREP: begin
        e_q <= tak_pkg::sat48(tak_pkg::sx52(cz_q) - tak_pkg::sx52(xa_q));
        g_q <= tak_pkg::sat48(tak_pkg::sx52(tak_pkg::Q_ONE) - tak_pkg::sx52(k0_q));
      end
      tak_pkg::CMD_STORE: begin
        oax_q  <= ax_q;
        oang_q <= nx0_q[47:16];
      end
      default: ;
    endcase
  end

  assign out_valid_o      = ovld_q;
  assign axis_out_o       = oax_q;
  assign angle_estimate_o = oang_q;

endmodule

`default_nettype wire

// ----- rtl/tilt_angle_kalman_filter_top.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter top level
// Two-bank angle and gyro bias estimator from accelerometer and gyro items.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item runs through every step below before its
// angle estimate is stored, and the next item is taken only after that store.
// The steps are the 40-step CORDIC, eleven products on the shared multiplier
// (each: four 24x24 partial products, round, saturate, write-back) and the
// 92-step bit-serial divider that forms both gains at once. A finished result
// waits in the output register while the next item runs. Filter state resets
// at once. The user must write config only while the block is idle; unchecked.
`timescale 1ns / 1ps
`default_nettype none

`include "tilt_angle_kalman_filter_top_defines.svh"

module tilt_angle_kalman_filter_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [44:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               axis_i,
  input  wire logic signed [15:0] accel_lateral_i,
  input  wire logic signed [15:0] accel_vertical_i,
  input  wire logic signed [31:0] gyro_rate_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    axis_out_o,
  output logic signed [31:0]      angle_estimate_o
);

  tak_pkg::tak_cmd_t    cmd;
  tak_pkg::tak_status_t status;

  tak_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tak_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .axis_i           (axis_i),
    .accel_lateral_i  (accel_lateral_i),
    .accel_vertical_i (accel_vertical_i),
    .gyro_rate_i      (gyro_rate_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .axis_out_o       (axis_out_o),
    .angle_estimate_o (angle_estimate_o)
  );

  `TAK_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> in_stall_o)
  `TAK_ASSERT(a_store_sets_valid, clk_i, rst_ni,
    (cmd.op == tak_pkg::CMD_STORE) |=> out_valid_o)
  `TAK_ASSERT(a_no_overwrite, clk_i, rst_ni,
    !(cmd.op == tak_pkg::CMD_STORE && out_valid_o && out_stall_i))
  `TAK_ASSERT_NORST(a_idle_no_work, clk_i,
    !in_stall_o |-> (cmd.op == tak_pkg::CMD_NOP || cmd.op == tak_pkg::CMD_ACCEPT))

endmodule

`default_nettype wire
